// File: rtl/dss_pkg.sv
package dss_pkg;

   // default sizing, handed to the top level parameters
   localparam int QUEUE_DEPTH_DEF = 1024;
   localparam int CYL_BITS_DEF    = 16;

   // fixed field widths of the ports
   localparam int CYL_FIELD_BITS  = 16;
   localparam int CSR_IDX_BITS    = 1;
   localparam int CSR_DATA_BITS   = 16;

   // operation codes
   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_SERVE   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // result status codes
   localparam logic [2:0] STATUS_ADDED     = 3'd0;
   localparam logic [2:0] STATUS_SERVED    = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_RESTARTED = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_POSITION = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POLICY_MODE    = 1'b1;

   // policy values
   localparam logic POLICY_FCFS = 1'b0;
   localparam logic POLICY_SSTF = 1'b1;

   typedef struct packed {
      logic [1:0]                op;
      logic [CYL_FIELD_BITS-1:0] cylinder;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]                status;
      logic [CYL_FIELD_BITS-1:0] served_cylinder;
      logic [CYL_FIELD_BITS-1:0] seek_distance;
      logic [31:0]               total_movement;
   } rsp_payload_type;

endpackage

// File: rtl/dss_ram.sv
module dss_ram
   import dss_pkg::*;
#(
   parameter int WIDTH = CYL_BITS_DEF,
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/disk_seek_scheduler_sstf_fcfs.sv
// add, restart, empty serve: result strobe in the cycle after the transfer
// serve with n slots scanned (n = pending count in sstf, 1 in fcfs): scan, then swap a and b,
//   then the result strobe; next transfer at the earliest in the strobe cycle
// the scan reads one slot per cycle from the single request ram, then two write states swap
// reset is synchronous, active high: table empty, head and total zero, sstf policy
// results are shown for one cycle only; the receiver cannot stall them
module disk_seek_scheduler_sstf_fcfs
   import dss_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int CYL_BITS    = CYL_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_payload_type          req_payload,
   output logic                     rsp_strobe,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // cylinders never exceed the 16-bit field, so slots hold the narrower of the two
   localparam int SLOT_BITS = (CYL_BITS < CYL_FIELD_BITS) ? CYL_BITS : CYL_FIELD_BITS;
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0] DEPTH_COUNT = CNT_BITS'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SWAP_A = 4'b0100,
      ST_SWAP_B = 4'b1000
   } state_type;

   // control state
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [CNT_BITS-1:0]   front_ff, front_in;
   logic [SLOT_BITS-1:0]  head_ff, head_in;
   logic [31:0]           sum_ff, sum_in;
   logic [SLOT_BITS-1:0]  start_pos_ff, start_pos_in;
   logic                  policy_ff, policy_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   // scan bookkeeping
   logic [CNT_BITS-1:0]   issue_ff, issue_in;
   logic [CNT_BITS-1:0]   scan_end_ff, scan_end_in;
   logic                  pend_ff, pend_in;
   logic [CNT_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic [SLOT_BITS-1:0]  front_val_ff, front_val_in;
   logic [SLOT_BITS-1:0]  best_val_ff, best_val_in;
   logic [SLOT_BITS-1:0]  best_gap_ff, best_gap_in;
   logic [ADDR_BITS-1:0]  pick_ff, pick_in;

   rsp_payload_type       rsp_ff, rsp_in;

   // ram port
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [SLOT_BITS-1:0]  wr_data;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [SLOT_BITS-1:0]  rd_data;

   logic                  accept;
   logic [SLOT_BITS-1:0]  req_cyl;
   logic [SLOT_BITS-1:0]  gap;
   logic [32:0]           sum_ext;
   logic [31:0]           sum_sat;

   dss_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign req_cyl = req_payload.cylinder[SLOT_BITS-1:0];

   // distance of the slot coming out of the ram to the current head
   assign gap = (rd_data >= head_ff) ? (rd_data - head_ff) : (head_ff - rd_data);

   // saturating total for the service being finished
   assign sum_ext = {1'b0, sum_ff} + 33'(best_gap_ff);
   assign sum_sat = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];

   // reads always follow the issue pointer; unused data is simply dropped
   assign rd_addr = issue_ff[ADDR_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      front_in      = front_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      start_pos_in  = start_pos_ff;
      policy_in     = policy_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      issue_in      = issue_ff;
      scan_end_in   = scan_end_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      front_val_in  = front_val_ff;
      best_val_in   = best_val_ff;
      best_gap_in   = best_gap_ff;
      pick_in       = pick_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[ADDR_BITS-1:0];
      wr_data       = req_cyl;

      // register writes, only while idle: a rule for the user, which the block itself does not enforce
      if (csr_we) begin
         case (csr_index)
            CSR_START_POSITION: start_pos_in = csr_wdata[SLOT_BITS-1:0];
            CSR_POLICY_MODE:    policy_in    = csr_wdata[0];
            default: ;
         endcase
      end

      // compare stage: data for the slot read last cycle
      if (pend_ff) begin
         if (pend_idx_ff == front_ff) begin
            front_val_in = rd_data;
            best_val_in  = rd_data;
            best_gap_in  = gap;
            pick_in      = pend_idx_ff[ADDR_BITS-1:0];
         end else if (gap < best_gap_ff) begin
            // strict compare keeps ties on the lowest slot
            best_val_in = rd_data;
            best_gap_in = gap;
            pick_in     = pend_idx_ff[ADDR_BITS-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.served_cylinder = '0;
               rsp_in.seek_distance   = '0;
               rsp_in.total_movement  = sum_ff;
               case (req_payload.op)
                  OP_ADD: begin
                     rsp_strobe_in = 1'b1;
                     if (fill_ff != DEPTH_COUNT) begin
                        wr_en          = 1'b1;
                        fill_in        = fill_ff + 1'b1;
                        rsp_in.status  = STATUS_ADDED;
                     end else begin
                        rsp_in.status  = STATUS_FULL;
                     end
                  end
                  OP_SERVE: begin
                     if (front_ff >= fill_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        state_in    = ST_SCAN;
                        issue_in    = front_ff;
                        scan_end_in = (policy_ff == POLICY_SSTF) ? fill_ff
                                                                 : front_ff + 1'b1;
                     end
                  end
                  OP_RESTART: begin
                     rsp_strobe_in         = 1'b1;
                     front_in              = '0;
                     fill_in               = '0;
                     sum_in                = '0;
                     head_in               = start_pos_ff;
                     rsp_in.status         = STATUS_RESTARTED;
                     rsp_in.total_movement = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff != scan_end_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
               issue_in    = issue_ff + 1'b1;
            end else begin
               // last compare lands at this same edge
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            wr_en    = 1'b1;
            wr_addr  = pick_ff;
            wr_data  = front_val_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            wr_en                  = 1'b1;
            wr_addr                = front_ff[ADDR_BITS-1:0];
            wr_data                = best_val_ff;
            front_in               = front_ff + 1'b1;
            head_in                = best_val_ff;
            sum_in                 = sum_sat;
            rsp_strobe_in          = 1'b1;
            rsp_in.status          = STATUS_SERVED;
            rsp_in.served_cylinder = CYL_FIELD_BITS'(best_val_ff);
            rsp_in.seek_distance   = CYL_FIELD_BITS'(best_gap_ff);
            rsp_in.total_movement  = sum_sat;
            state_in               = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         front_ff      <= '0;
         head_ff       <= '0;
         sum_ff        <= '0;
         start_pos_ff  <= '0;
         policy_ff     <= POLICY_SSTF;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         front_ff      <= front_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
         start_pos_ff  <= start_pos_in;
         policy_ff     <= policy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
      end
   end

   // payload and scan data, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      issue_ff     <= issue_in;
      scan_end_ff  <= scan_end_in;
      pend_idx_ff  <= pend_idx_in;
      front_val_ff <= front_val_in;
      best_val_ff  <= best_val_in;
      best_gap_ff  <= best_gap_in;
      pick_ff      <= pick_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // add and restart always answer in the next cycle
   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.op == OP_ADD || req_payload.op == OP_RESTART) |=> rsp_strobe)
      else $error("add or restart transfer gave no result");

   // the unused op never produces a result
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.op == OP_NONE |=> !rsp_strobe)
      else $error("unused op produced a result");

   // pending window stays inside the table
   a_window: assert property (@(posedge clock) disable iff (reset)
      front_ff <= fill_ff && fill_ff <= DEPTH_COUNT)
      else $error("front or fill pointer out of range");

   // finishing a swap reports a service
   a_served: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWAP_B |=> rsp_strobe && rsp_payload.status == STATUS_SERVED && !busy)
      else $error("swap finished without a served result");

endmodule
